// ===== src/ntgc_pkg.sv =====
// Package with the beat types, control types, constants and font table of the glyph column renderer.
`timescale 1ns / 1ps

package ntgc_pkg;

    typedef enum logic [1:0] {
        ACT_NUMBER    = 2'd0,
        ACT_TWO_DIGIT = 2'd1,
        ACT_GLYPH     = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [15:0] number;
        logic [4:0]  glyph_code;
    } t_in_item;

    typedef struct packed {
        logic [7:0] top_byte;
        logic [7:0] bottom_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PREP = 2'd1,
        ST_EMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic prep;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic in_none;
        logic col_end;
        logic glyph_end;
        logic out_free;
    } t_dp_sts;

    localparam int unsigned MAX_DIGITS  = 5;
    localparam int unsigned COL_W       = 3;
    localparam int unsigned GLYPH_IDX_W = 3;
    localparam logic [4:0]  GLYPH_BLANK = 5'd20;
    localparam logic [4:0]  GLYPH_COUNT = 5'd21;
    localparam logic [COL_W-1:0] GAP_COLS = 3'd3;
    localparam logic [COL_W-1:0] COL_LAST = 3'd7;
    localparam logic [15:0] TWO_DIGIT_MAX = 16'd99;

    localparam logic [16:0] POW10 [MAX_DIGITS+1] = '{
        17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000, 17'd100000
    };

    function automatic logic [4:0] clean_code(input logic [4:0] code);
        clean_code = (code >= GLYPH_COUNT) ? GLYPH_BLANK : code;
    endfunction

    // Five font columns, column 0 in the low bits, each as {bottom, top}.
    function automatic logic [79:0] glyph_row(input logic [4:0] code);
        logic [79:0] row;
        unique case (code)
            5'd0:    row = 80'h1F7C_2002_2002_2002_1F7C;
            5'd1:    row = 80'h1F7C_0000_0000_0000_0000;
            5'd2:    row = 80'h007C_2082_2082_2082_1F00;
            5'd3:    row = 80'h1F7C_2082_2082_2082_0000;
            5'd4:    row = 80'h1F7C_0080_0080_0080_007C;
            5'd5:    row = 80'h1F00_2082_2082_2082_007C;
            5'd6:    row = 80'h1F00_2082_2082_2082_1F7C;
            5'd7:    row = 80'h1F7C_0002_0002_0002_007C;
            5'd8:    row = 80'h1F7C_2082_2082_2082_1F7C;
            5'd9:    row = 80'h1F7C_2082_2082_2082_007C;
            5'd10:   row = 80'h3F7C_0082_0082_0082_3F7C;
            5'd11:   row = 80'h037C_0C00_3000_0C00_037C;
            5'd12:   row = 80'h1F7C_2000_3F00_2000_1F7C;
            5'd13:   row = 80'h3F00_0080_0080_0080_3F7C;
            5'd14:   row = 80'h3F00_0080_3F80_0080_3F00;
            5'd15:   row = 80'h0000_2082_2082_2082_1F7C;
            5'd16:   row = 80'h1F7C_0002_0002_0002_1F7C;
            5'd17:   row = 80'h007C_0082_0082_0082_1F7C;
            5'd18:   row = 80'h0002_0002_3F7E_0002_0002;
            5'd19:   row = 80'h0000_0000_0630_0630_0000;
            default: row = 80'h0;
        endcase
        glyph_row = row;
    endfunction

    // Returns {bottom, top} for display column col of a glyph, gap columns first.
    function automatic logic [15:0] glyph_column(input logic [4:0] code,
                                                 input logic [COL_W-1:0] col);
        logic [79:0]      row;
        logic [COL_W-1:0] idx;
        row = glyph_row(code);
        idx = col - GAP_COLS;
        if (col < GAP_COLS) begin
            glyph_column = 16'h0;
        end else begin
            glyph_column = row[16*idx +: 16];
        end
    endfunction

endpackage

// ===== src/number_to_glyph_columns.sv =====
// Top level of the glyph column renderer: controller and datapath.
// An accepted request passes the PREP state, the EMIT state and the output register
// before its first column beat; no new request is taken until its last column is emitted.
// G glyphs are shown, G being DIGIT_COUNT, 2 or 1 for actions 0, 1, 2, each after a
// PREP step for its digit; one column per cycle with no output stall. Action 3 gives no beats.
// Reset: synchronous, active low; clears the state machine, the counters and output valid.
`timescale 1ns / 1ps

module number_to_glyph_columns #(
    parameter int unsigned DIGIT_COUNT = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ntgc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ntgc_pkg::t_out_item o_out_data
);

    ntgc_pkg::t_dp_cmd cmd;
    ntgc_pkg::t_dp_sts sts;

    ntgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ntgc_dp #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== src/ntgc_ctrl.sv =====
// Controller state machine that sequences digit extraction and column output.
`timescale 1ns / 1ps

module ntgc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ntgc_pkg::t_dp_sts i_sts,
    output ntgc_pkg::t_dp_cmd o_cmd
);

    ntgc_pkg::t_state r_state;
    ntgc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntgc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ntgc_pkg::ST_IDLE: begin
                if (i_in_valid && !i_sts.in_none) begin
                    n_state = ntgc_pkg::ST_PREP;
                end
            end
            ntgc_pkg::ST_PREP: begin
                n_state = ntgc_pkg::ST_EMIT;
            end
            ntgc_pkg::ST_EMIT: begin
                if (i_sts.out_free && i_sts.col_end) begin
                    n_state = i_sts.glyph_end ? ntgc_pkg::ST_IDLE : ntgc_pkg::ST_PREP;
                end
            end
            default: n_state = ntgc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ntgc_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ntgc_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
            end
            ntgc_pkg::ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/ntgc_dp.sv =====
// Datapath: operand capture, digit extraction, glyph counters, font lookup and output register.
`timescale 1ns / 1ps

module ntgc_dp #(
    parameter int unsigned DIGIT_COUNT = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntgc_pkg::t_in_item  i_in_data,
    input  ntgc_pkg::t_dp_cmd   i_cmd,
    output ntgc_pkg::t_dp_sts   o_sts,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ntgc_pkg::t_out_item o_out_data
);

    localparam logic [16:0] NUM_LIMIT = ntgc_pkg::POW10[DIGIT_COUNT] - 17'd1;
    localparam logic [ntgc_pkg::GLYPH_IDX_W-1:0] LAST_DIGIT =
        ntgc_pkg::GLYPH_IDX_W'(DIGIT_COUNT - 1);

    ntgc_pkg::t_action                 r_action;
    logic [15:0]                       r_rem;
    logic [4:0]                        r_lead;
    logic [4:0]                        r_code;
    logic                              r_shown;
    logic [ntgc_pkg::GLYPH_IDX_W-1:0]  r_glyph;
    logic [ntgc_pkg::GLYPH_IDX_W-1:0]  r_glyph_last;
    logic [ntgc_pkg::COL_W-1:0]        r_col;
    logic                              r_out_valid;
    ntgc_pkg::t_out_item               r_out;

    logic [ntgc_pkg::GLYPH_IDX_W-1:0]  place;
    logic [3:0]                        digit;
    logic [16:0]                       sub_val;
    logic [15:0]                       n_rem;
    logic                              n_shown;
    logic [4:0]                        n_code;
    logic [15:0]                       load_num;
    logic [ntgc_pkg::GLYPH_IDX_W-1:0]  load_last;
    logic [15:0]                       column;
    logic                              col_end;
    logic                              glyph_end;

    assign col_end   = (r_col == ntgc_pkg::COL_LAST);
    assign glyph_end = (r_glyph == r_glyph_last);

    assign o_sts.in_none   = (i_in_data.action == ntgc_pkg::ACT_NONE);
    assign o_sts.col_end   = col_end;
    assign o_sts.glyph_end = glyph_end;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    // Operand saturation at capture time.
    always_comb begin
        load_num  = i_in_data.number;
        load_last = '0;
        unique case (i_in_data.action)
            ntgc_pkg::ACT_NUMBER: begin
                if ({1'b0, i_in_data.number} > NUM_LIMIT) begin
                    load_num = NUM_LIMIT[15:0];
                end
                load_last = LAST_DIGIT;
            end
            ntgc_pkg::ACT_TWO_DIGIT: begin
                if (i_in_data.number > ntgc_pkg::TWO_DIGIT_MAX) begin
                    load_num = ntgc_pkg::TWO_DIGIT_MAX;
                end
                load_last = ntgc_pkg::GLYPH_IDX_W'(1);
            end
            default: load_last = '0;
        endcase
    end

    // One decimal digit per glyph: compare against every multiple of the current place.
    always_comb begin
        if (r_action == ntgc_pkg::ACT_NUMBER) begin
            place = LAST_DIGIT - r_glyph;
        end else begin
            place = ntgc_pkg::GLYPH_IDX_W'(1) - r_glyph;
        end
        digit   = 4'd0;
        sub_val = 17'd0;
        for (int i = 0; i < ntgc_pkg::MAX_DIGITS; i++) begin
            for (int k = 1; k < 10; k++) begin
                if (place == ntgc_pkg::GLYPH_IDX_W'(i)
                        && {1'b0, r_rem} >= 17'(k) * ntgc_pkg::POW10[i]) begin
                    digit   = 4'(k);
                    sub_val = 17'(k) * ntgc_pkg::POW10[i];
                end
            end
        end
        n_rem = r_rem - sub_val[15:0];
    end

    always_comb begin
        n_shown = r_shown;
        unique case (r_action)
            ntgc_pkg::ACT_NUMBER: begin
                // Leading zeros stay blank; the final digit always shows.
                n_shown = r_shown || (digit != 4'd0) || (r_glyph == LAST_DIGIT);
                n_code  = n_shown ? {1'b0, digit} : ntgc_pkg::GLYPH_BLANK;
            end
            ntgc_pkg::ACT_TWO_DIGIT: begin
                n_code = (r_glyph == '0 && digit == 4'd0) ? r_lead : {1'b0, digit};
            end
            default: n_code = r_lead;
        endcase
    end

    assign column = ntgc_pkg::glyph_column(r_code, r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph     <= '0;
            r_col       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_glyph <= '0;
                r_col   <= '0;
            end else if (i_cmd.emit) begin
                r_col <= r_col + ntgc_pkg::COL_W'(1);
                if (col_end) begin
                    r_glyph <= r_glyph + ntgc_pkg::GLYPH_IDX_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action     <= i_in_data.action;
            r_rem        <= load_num;
            r_lead       <= ntgc_pkg::clean_code(i_in_data.glyph_code);
            r_shown      <= 1'b0;
            r_glyph_last <= load_last;
        end
        if (i_cmd.prep) begin
            r_rem   <= n_rem;
            r_shown <= n_shown;
            r_code  <= n_code;
        end
        if (i_cmd.emit) begin
            r_out.top_byte    <= column[7:0];
            r_out.bottom_byte <= column[15:8];
            r_out.last        <= col_end && glyph_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_glyph_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_glyph <= r_glyph_last)
        else $error("glyph counter ran past the last glyph of the request");

    a_load_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> r_col == '0 && r_glyph == '0)
        else $error("counters not cleared after a request was taken");

    a_prep_at_glyph_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.prep |-> r_col == '0)
        else $error("digit extraction outside a glyph boundary");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && col_end && glyph_end |=> r_out_valid && r_out.last)
        else $error("final column of a request not marked last");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench of the glyph column renderer, built around a small scoreboard class.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DIGITS      = 5;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_REQS = 220;
    localparam int unsigned IDLE_PCT    = 22;
    localparam int unsigned CODE_COUNT  = 21;
    localparam int unsigned GAP_WIDTH   = 3;
    localparam int unsigned FONT_WIDTH  = 5;
    localparam int unsigned DRAIN_HOLD  = 12;
    localparam logic [4:0]  BLANK_CODE  = 5'd20;

    // Font columns from left to right, each column as {top, bottom}.
    localparam logic [79:0] FONT_ROWS [CODE_COUNT] = '{
        80'h7C1F_0220_0220_0220_7C1F,
        80'h0000_0000_0000_0000_7C1F,
        80'h001F_8220_8220_8220_7C00,
        80'h0000_8220_8220_8220_7C1F,
        80'h7C00_8000_8000_8000_7C1F,
        80'h7C00_8220_8220_8220_001F,
        80'h7C1F_8220_8220_8220_001F,
        80'h7C00_0200_0200_0200_7C1F,
        80'h7C1F_8220_8220_8220_7C1F,
        80'h7C00_8220_8220_8220_7C1F,
        80'h7C3F_8200_8200_8200_7C3F,
        80'h7C03_000C_0030_000C_7C03,
        80'h7C1F_0020_003F_0020_7C1F,
        80'h7C3F_8000_8000_8000_003F,
        80'h003F_8000_803F_8000_003F,
        80'h7C1F_8220_8220_8220_0000,
        80'h7C1F_0200_0200_0200_7C1F,
        80'h7C1F_8200_8200_8200_7C00,
        80'h0200_0200_7E3F_0200_0200,
        80'h0000_3006_3006_0000_0000,
        80'h0000_0000_0000_0000_0000
    };

    class glyph_scoreboard;
        ntgc_pkg::t_out_item expected_columns[$];
        ntgc_pkg::t_out_item request_cols[$];
        int unsigned         errors;

        function new();
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_columns.size();
        endfunction

        // Three blank gap columns, then the five font columns of the glyph.
        function void append_glyph(logic [4:0] code);
            logic [79:0]         row;
            ntgc_pkg::t_out_item col;
            row = FONT_ROWS[(code >= CODE_COUNT) ? BLANK_CODE : code];
            col = '0;
            for (int c = 0; c < GAP_WIDTH; c++) request_cols.push_back(col);
            for (int c = 0; c < FONT_WIDTH; c++) begin
                {col.top_byte, col.bottom_byte} = row[79 - 16 * c -: 16];
                request_cols.push_back(col);
            end
        endfunction

        function void note_request(ntgc_pkg::t_in_item req);
            int unsigned         value;
            int unsigned         place;
            int unsigned         digit;
            int unsigned         tens;
            bit                  shown;
            ntgc_pkg::t_out_item tail;
            request_cols.delete();
            case (req.action)
                ntgc_pkg::ACT_NUMBER: begin
                    place = 1;
                    for (int d = 1; d < DIGITS; d++) place = place * 10;
                    value = 32'(req.number);
                    if (value > place * 10 - 1) value = place * 10 - 1;
                    shown = 1'b0;
                    for (int d = 0; d < DIGITS; d++) begin
                        digit = value / place;
                        value = value % place;
                        if (digit != 0 || d == DIGITS - 1) shown = 1'b1;
                        append_glyph(shown ? 5'(digit) : BLANK_CODE);
                        place = place / 10;
                    end
                end
                ntgc_pkg::ACT_TWO_DIGIT: begin
                    value = (req.number > 16'd99) ? 32'd99 : 32'(req.number);
                    tens  = value / 10;
                    append_glyph((tens != 0) ? 5'(tens) : req.glyph_code);
                    append_glyph(5'(value % 10));
                end
                ntgc_pkg::ACT_GLYPH: begin
                    append_glyph(req.glyph_code);
                end
                default: begin
                    return;
                end
            endcase
            tail = request_cols.pop_back();
            tail.last = 1'b1;
            request_cols.push_back(tail);
            foreach (request_cols[i]) expected_columns.push_back(request_cols[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns: %s", $time, msg);
        endtask

        task check_column(ntgc_pkg::t_out_item got);
            ntgc_pkg::t_out_item want;
            if (expected_columns.size() == 0) begin
                report($sformatf("unexpected column beat top %02h bottom %02h last %0b",
                                 got.top_byte, got.bottom_byte, got.last));
                return;
            end
            want = expected_columns.pop_front();
            if (got.top_byte !== want.top_byte) begin
                report($sformatf("top byte %02h, expected %02h", got.top_byte, want.top_byte));
            end
            if (got.bottom_byte !== want.bottom_byte) begin
                report($sformatf("bottom byte %02h, expected %02h",
                                 got.bottom_byte, want.bottom_byte));
            end
            if (got.last !== want.last) begin
                report($sformatf("last flag %0b, expected %0b", got.last, want.last));
            end
        endtask
    endclass

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    ntgc_pkg::t_in_item  in_beat   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ntgc_pkg::t_out_item out_beat;
    logic                calm      = 1'b0;
    int unsigned         cycle_count = 0;
    glyph_scoreboard     sb;

    number_to_glyph_columns #(.DIGIT_COUNT(DIGITS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            if (i_rst_n && in_valid && !in_stall) sb.note_request(in_beat);
            if (i_rst_n && out_valid && !out_stall) sb.check_column(out_beat);
        end
    end

    function automatic ntgc_pkg::t_in_item make_request(ntgc_pkg::t_action act,
                                                         logic [15:0] num,
                                                         logic [4:0] code);
        ntgc_pkg::t_in_item req;
        req.action     = act;
        req.number     = num;
        req.glyph_code = code;
        return req;
    endfunction

    function automatic ntgc_pkg::t_in_item random_request();
        ntgc_pkg::t_in_item req;
        int unsigned        pick;
        pick = $urandom_range(99);
        req.action = (pick < 30) ? ntgc_pkg::ACT_NUMBER :
                     (pick < 60) ? ntgc_pkg::ACT_TWO_DIGIT :
                     (pick < 92) ? ntgc_pkg::ACT_GLYPH : ntgc_pkg::ACT_NONE;
        case ($urandom_range(3))
            0:       req.number = 16'($urandom);
            1:       req.number = 16'($urandom_range(120));
            2:       req.number = 16'($urandom_range(9999));
            default: req.number = 16'($urandom_range(10010, 9990));
        endcase
        // Mostly valid glyph codes, some out of range to hit the blank fallback.
        if ($urandom_range(3) == 0) begin
            req.glyph_code = 5'($urandom_range(31));
        end else begin
            req.glyph_code = 5'($urandom_range(20));
        end
        return req;
    endfunction

    task automatic send_request(ntgc_pkg::t_in_item req);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= req;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Hold the sender until every expected column has come back.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_HOLD) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd0, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd1, 5'd31));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd9, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd10, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd99, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd100, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd12345, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'hFFFF, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd10000, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_NUMBER, 16'd9999, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd0, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd5, 5'd20));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd7, 5'd31));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd10, 5'd4));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd99, 5'd3));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd100, 5'd15));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'hFFFF, 5'd19));
        send_request(make_request(ntgc_pkg::ACT_TWO_DIGIT, 16'd42, 5'd12));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'd0, 5'd0));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'd0, 5'd18));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'd0, 5'd19));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'd0, 5'd20));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'd0, 5'd21));
        send_request(make_request(ntgc_pkg::ACT_GLYPH, 16'hFFFF, 5'd31));
        send_request(make_request(ntgc_pkg::ACT_NONE, 16'hFFFF, 5'd31));
    endtask

    task automatic run_random();
        ntgc_pkg::t_in_item req;
        int unsigned        sent;
        sent = 0;
        while (sent < RANDOM_REQS) begin
            // A stretch in the middle runs with no idling on either side.
            calm <= (sent >= 100 && sent < 160);
            req = random_request();
            send_request(req);
            if (req.action != ntgc_pkg::ACT_NONE) sent++;
        end
        calm <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        wait_for_drain();
        run_random();
        wait_for_drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== number_to_glyph_columns.f =====
src/ntgc_pkg.sv
src/ntgc_ctrl.sv
src/ntgc_dp.sv
src/number_to_glyph_columns.sv
bench/tb_top.sv
